@@ rtl/tbr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbr_pkg
// Types and constants shared by the tape block reframer modules.
// ----------------------------------------------------------------------------
package tbr_pkg;

	localparam int FLEN_W   = 24;
	localparam int PAUSE_W  = 16;
	localparam int LEN_W    = 16;
	localparam int BYTE_W   = 8;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int IDX_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MS    = 2'd1;

	localparam logic [PAUSE_W-1:0] PAUSE_RESET = 16'd1000;
	localparam logic [BYTE_W-1:0]  BLOCK_ID    = 8'h10;

	// index of the final byte of the signature and header bursts
	localparam logic [IDX_W-1:0] SIG_LAST = 4'd9;
	localparam logic [IDX_W-1:0] HDR_LAST = 4'd4;

	// header byte positions
	localparam logic [IDX_W-1:0] HDR_ID       = 4'd0;
	localparam logic [IDX_W-1:0] HDR_PAUSE_LO = 4'd1;
	localparam logic [IDX_W-1:0] HDR_PAUSE_HI = 4'd2;
	localparam logic [IDX_W-1:0] HDR_LEN_LO   = 4'd3;
	localparam logic [IDX_W-1:0] HDR_LEN_HI   = 4'd4;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_LEN_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_DATA   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		BK_SIG  = 2'd0,
		BK_HDR  = 2'd1,
		BK_DATA = 2'd2
	} burst_kind_t;

	// one burst of output bytes caused by one input beat
	typedef struct packed {
		burst_kind_t         kind;
		logic [BYTE_W-1:0]   data;
		logic [PAUSE_W-1:0]  pause;
		logic [LEN_W-1:0]    length;
	} burst_t;

	// container signature: "ZXTape!", 0x1A, major 1, minor 3
	function automatic logic [BYTE_W-1:0] sig_byte(input logic [IDX_W-1:0] i);
		logic [BYTE_W-1:0] b;
		case (i)
			4'd0:    b = 8'h5A;
			4'd1:    b = 8'h58;
			4'd2:    b = 8'h54;
			4'd3:    b = 8'h61;
			4'd4:    b = 8'h70;
			4'd5:    b = 8'h65;
			4'd6:    b = 8'h21;
			4'd7:    b = 8'h1A;
			4'd8:    b = 8'h01;
			4'd9:    b = 8'h03;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

@@ rtl/tape_block_reframer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tape_block_reframer_core
// Reframes a raw tape image, a byte per beat, into a container byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / image_byte): one image byte a beat.
//  - Output channel (out_valid / out_stall / out_byte / run_last): container
//    bytes; run_last marks the final byte caused by one input beat.
//  - Config port (cfg_write / cfg_index / cfg_data): index 0 file_length,
//    index 1 pause_ms; other indexes are dropped. Write only while idle.
//  - First beat: the 10-byte signature; length-high beat with a nonzero
//    length: a 5-byte block header; data beat: one byte; others: none.
//  - Path: a beat's output passes the parser register, then the emitter
//    register, before its first byte appears on the output channel.
//  - Throughput: one beat a cycle while each beat yields at most one byte
//    and out_stall is low; a header or signature holds the emitter to its
//    last byte, and the parser register absorbs one further beat meanwhile.
//  - Output stall: the emitter holds its byte, the parser register fills,
//    then in_stall rises; nothing is lost.
//  - Reset: signature pending, position and counts zero, file_length 0,
//    pause_ms 1000, both channels empty.
// ----------------------------------------------------------------------------
module tape_block_reframer_core #(
	parameter int POSITION_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [tbr_pkg::BYTE_W-1:0]      image_byte,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [tbr_pkg::BYTE_W-1:0]           out_byte,
	output logic                                 run_last,
	input  wire logic                            cfg_write,
	input  wire logic [tbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tbr_pkg::CFG_W-1:0]       cfg_data
);
	import tbr_pkg::*;

	logic [FLEN_W-1:0]   file_length_q;
	logic [PAUSE_W-1:0]  pause_ms_q;
	logic                burst_valid;
	burst_t              burst;
	logic                burst_take;

	// config registers; take effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			pause_ms_q    <= PAUSE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FILE_LENGTH: file_length_q <= cfg_data[FLEN_W-1:0];
				REG_PAUSE_MS:    pause_ms_q    <= cfg_data[PAUSE_W-1:0];
				default: ;
			endcase
		end
	end

	// framing state and one-deep burst register
	tbr_parser #(
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.image_byte  (image_byte),
		.file_length (file_length_q),
		.pause_ms    (pause_ms_q),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_take  (burst_take)
	);

	// byte-per-beat playout of the current burst
	tbr_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_valid (burst_valid),
		.burst       (burst),
		.burst_take  (burst_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire

@@ rtl/tbr_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbr_parser
// Tracks the image framing and turns each input beat into at most one burst.
// ----------------------------------------------------------------------------
module tbr_parser #(
	parameter int POSITION_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tbr_pkg::BYTE_W-1:0]    image_byte,
	input  wire logic [tbr_pkg::FLEN_W-1:0]    file_length,
	input  wire logic [tbr_pkg::PAUSE_W-1:0]   pause_ms,
	output logic                               burst_valid,
	output tbr_pkg::burst_t                    burst,
	input  wire logic                          burst_take
);
	import tbr_pkg::*;

	localparam int CMP_W = ((POSITION_BITS > FLEN_W) ? POSITION_BITS : FLEN_W) + 1;

	phase_t                    phase_q, phase_d;
	logic [POSITION_BITS-1:0]  pos_q, pos_d, pos_inc;
	logic [LEN_W-1:0]          remain_q, remain_d, remain_dec;
	logic [BYTE_W-1:0]         len_lo_q, len_lo_d;
	logic                      valid_s1;
	burst_t                    burst_s1, burst_d;
	logic                      emit_d;
	logic                      accept;
	phase_t                    eff_phase;
	logic [LEN_W-1:0]          length;
	logic [CMP_W-1:0]          flen_ext, pos_ext, end_sum;

	assign in_stall    = valid_s1 && !burst_take;
	assign accept      = in_valid && !in_stall;
	assign burst_valid = valid_s1;
	assign burst       = burst_s1;

	// saturating position advance
	assign pos_inc    = (pos_q == {POSITION_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;
	assign remain_dec = remain_q - 1'b1;
	assign length     = {image_byte, len_lo_q};
	assign flen_ext   = CMP_W'(file_length);
	assign pos_ext    = CMP_W'(pos_q);
	assign end_sum    = CMP_W'(pos_inc) + CMP_W'(length);
	assign eff_phase  = (phase_q == PH_START) ? PH_LEN_LO : phase_q;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		remain_d = remain_q;
		len_lo_d = len_lo_q;
		emit_d   = 1'b0;
		burst_d.kind   = BK_SIG;
		burst_d.data   = image_byte;
		burst_d.pause  = pause_ms;
		burst_d.length = length;
		if (phase_q == PH_START) begin
			emit_d = 1'b1;
		end
		case (eff_phase)
			PH_LEN_LO: begin
				if (pos_ext >= flen_ext) begin
					phase_d = PH_DONE;
				end else begin
					len_lo_d = image_byte;
					pos_d    = pos_inc;
					phase_d  = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				pos_d = pos_inc;
				if (length == '0) begin
					phase_d = PH_DONE;
				end else begin
					emit_d       = 1'b1;
					burst_d.kind = BK_HDR;
					if (end_sum >= flen_ext) begin
						burst_d.pause = '0;
					end
					remain_d = length;
					phase_d  = PH_DATA;
				end
			end
			PH_DATA: begin
				emit_d       = 1'b1;
				burst_d.kind = BK_DATA;
				pos_d        = pos_inc;
				remain_d     = remain_dec;
				if (remain_dec == '0) begin
					phase_d = PH_LEN_LO;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			pos_q    <= '0;
			remain_q <= '0;
			len_lo_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				remain_q <= remain_d;
				len_lo_q <= len_lo_d;
			end
			if (accept && emit_d) begin
				valid_s1 <= 1'b1;
			end else if (burst_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit_d) begin
			burst_s1 <= burst_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/tbr_emitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbr_emitter
// Holds one burst and plays it out a byte per beat on the output channel.
// ----------------------------------------------------------------------------
module tbr_emitter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        burst_valid,
	input  wire tbr_pkg::burst_t             burst,
	output logic                             burst_take,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [tbr_pkg::BYTE_W-1:0]       out_byte,
	output logic                             run_last
);
	import tbr_pkg::*;

	logic              busy_q;
	burst_t            burst_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  last_idx;
	logic              at_last;

	always_comb begin
		case (burst_q.kind)
			BK_SIG:  last_idx = SIG_LAST;
			BK_HDR:  last_idx = HDR_LAST;
			default: last_idx = '0;
		endcase
	end

	assign at_last    = (idx_q == last_idx);
	assign burst_take = burst_valid && (!busy_q || (!out_stall && at_last));
	assign out_valid  = busy_q;
	assign run_last   = at_last;

	always_comb begin
		case (burst_q.kind)
			BK_SIG: out_byte = sig_byte(idx_q);
			BK_HDR: begin
				case (idx_q)
					HDR_ID:       out_byte = BLOCK_ID;
					HDR_PAUSE_LO: out_byte = burst_q.pause[7:0];
					HDR_PAUSE_HI: out_byte = burst_q.pause[15:8];
					HDR_LEN_LO:   out_byte = burst_q.length[7:0];
					HDR_LEN_HI:   out_byte = burst_q.length[15:8];
					default:      out_byte = BLOCK_ID;
				endcase
			end
			default: out_byte = burst_q.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (burst_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && !out_stall) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_take) begin
			burst_q <= burst;
		end
	end

endmodule
`default_nettype wire

@@ test/tape_block_reframer_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tape_block_reframer_core_tb
// Self-checking bench: feeds tape image bytes through the reframer and checks
// every container byte against a beat-by-beat model of the conversion.
// A short table of directed beats and register writes comes first, then
// random blocks with random lengths, pauses and file lengths, ending the
// conversion by a zero length or by the file length check.
// ----------------------------------------------------------------------------
module tape_block_reframer_core_tb;

	import tbr_pkg::*;

	localparam int POS_W        = 24;
	localparam int DRAIN_CYCLES = 8;    // parser + emitter latency, with margin
	localparam int RANDOM_BEATS = 400;

	// indexes past the two registers; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [FLEN_W-1:0] FLEN_MAX  = 24'hFF_FFFF;
	localparam logic [PAUSE_W-1:0] PAUSE_MAX = 16'hFFFF;

	// "ZXTape!", 0x1A, 1, 3 - first byte in the low octet
	localparam logic [79:0] SIGNATURE = 80'h03_01_1A_21_65_70_61_54_58_5A;

	typedef enum logic { ROW_WRITE, ROW_BEAT } row_kind_t;

	// one line of the directed table: a register write or an image byte,
	// optionally with its container bytes spelt out
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       value;
		logic                   typed;
		logic [3:0]             n;
		logic [79:0]            bytes;
	} stim_row_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} container_byte_t;

	localparam int N_DIRECTED = 30;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic [BYTE_W-1:0]      image_byte = '0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [BYTE_W-1:0]      out_byte;
	logic                   run_last;
	logic                   cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index  = '0;
	logic [CFG_W-1:0]       cfg_data   = '0;

	// conversion model state, mirrors the block after reset
	phase_t                 tr_phase    = PH_START;
	logic [POS_W-1:0]       tr_pos      = '0;
	logic [LEN_W-1:0]       tr_left     = '0;
	logic [BYTE_W-1:0]      tr_len_lo   = '0;
	logic [FLEN_W-1:0]      tr_file_len = '0;
	logic [PAUSE_W-1:0]     tr_pause    = PAUSE_RESET;

	container_byte_t        container_q [$];
	stim_row_t              directed_rows [N_DIRECTED];

	bit                     calm        = 1'b0;   // no idling on either side
	int                     hold_left   = 0;
	int                     fault_count = 0;
	int                     beats_sent  = 0;
	int                     bytes_checked = 0;
	int                     headers_seen = 0;
	int                     writes_done = 0;
	string                  end_reason  = "";

	tape_block_reframer_core #(
		.POSITION_BITS(POS_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.image_byte (image_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Conversion model: one accepted image byte in, its container bytes
	// out (byte i in bits 8i+7:8i), n of them.
	// ------------------------------------------------------------------
	task automatic reframe_beat(input logic [BYTE_W-1:0] b, output int n,
			output logic [79:0] bytes);
		logic [LEN_W-1:0]   blen;
		logic [PAUSE_W-1:0] pause;
		logic [POS_W:0]     reach;
		n     = 0;
		bytes = '0;
		// very first beat: signature, then treated as a length low byte
		if (tr_phase == PH_START) begin
			bytes    = SIGNATURE;
			n        = 10;
			tr_phase = PH_LEN_LO;
		end
		case (tr_phase)
			PH_LEN_LO: begin
				// block start at or past the file length closes the conversion
				if (tr_pos >= tr_file_len) begin
					tr_phase = PH_DONE;
				end else begin
					tr_len_lo = b;
					if (~&tr_pos) tr_pos++;
					tr_phase = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				blen = {b, tr_len_lo};
				if (~&tr_pos) tr_pos++;
				if (blen == '0) begin
					tr_phase = PH_DONE;
				end else begin
					// last block gets no pause; sum taken one bit wider, no wrap
					reach = {1'b0, tr_pos} + (POS_W+1)'(blen);
					pause = (reach >= tr_file_len) ? '0 : tr_pause;
					bytes[8*n +: 40] = {blen[15:8], blen[7:0], pause[15:8], pause[7:0],
						BLOCK_ID};
					n += 5;
					tr_left  = blen;
					tr_phase = PH_DATA;
					headers_seen++;
				end
			end
			PH_DATA: begin
				bytes[8*n +: 8] = b;
				n++;
				if (~&tr_pos) tr_pos++;
				tr_left--;
				if (tr_left == '0) tr_phase = PH_LEN_LO;
			end
			default: begin
				tr_phase = PH_DONE;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Input side: optional gap, then hold the beat until it is taken.
	// Valid is only dropped when a gap follows, so a back-to-back beat
	// never sees valid lowered and raised in one step.
	// ------------------------------------------------------------------
	task automatic send_image_byte(input logic [BYTE_W-1:0] value, input logic typed,
			input logic [3:0] typed_n, input logic [79:0] typed_bytes);
		int              gap;
		int              n;
		logic [79:0]     bytes;
		container_byte_t cb;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		image_byte <= value;
		do @(posedge clk); while (in_stall);
		reframe_beat(value, n, bytes);
		// directed rows with spelt-out bytes override the model's output
		if (typed) begin
			n     = typed_n;
			bytes = typed_bytes;
		end
		for (int i = 0; i < n; i++) begin
			cb.data = bytes[8*i +: 8];
			cb.last = (i == n - 1);
			container_q.push_back(cb);
		end
		beats_sent++;
	endtask

	// idle = every expected byte out, plus time for a beat that makes none
	task automatic wait_idle();
		while (container_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_FILE_LENGTH: tr_file_len = value[FLEN_W-1:0];
			REG_PAUSE_MS:    tr_pause    = value[PAUSE_W-1:0];
			default: ;
		endcase
		cfg_write <= 1'b0;
		writes_done++;
	endtask

	function automatic stim_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_WRITE;
		r.idx   = idx;
		r.value = value;
		return r;
	endfunction

	function automatic stim_row_t row_beat(input logic [BYTE_W-1:0] b, input logic typed = 1'b0,
			input logic [3:0] n = '0, input logic [79:0] bytes = '0);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_BEAT;
		r.value = CFG_W'(b);
		r.typed = typed;
		r.n     = n;
		r.bytes = bytes;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Output side: check each beat against the oldest expectation, then
	// draw the stall that follows it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		container_byte_t want;
		if (out_valid && !out_stall) begin
			if (container_q.size() == 0) begin
				$display("%0t: unexpected container byte: expected none, got %h run_last %b",
					$time, out_byte, run_last);
				fault_count++;
			end else begin
				want = container_q.pop_front();
				if (out_byte !== want.data) begin
					$display("%0t: out_byte mismatch: expected %h, got %h",
						$time, want.data, out_byte);
					fault_count++;
				end
				if (run_last !== want.last) begin
					$display("%0t: run_last mismatch: expected %b, got %b",
						$time, want.last, run_last);
					fault_count++;
				end
				bytes_checked++;
			end
			hold_left = calm ? 0 : $urandom_range(0, 10);
		end else if (hold_left != 0) begin
			hold_left--;
		end
		out_stall <= (hold_left != 0);
	end

	// hard stop, several times the slowest legal run
	initial begin
		#10_000_000;
		$display("tape_block_reframer_core verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		logic [LEN_W-1:0]  blen;
		int                scenario;
		int                random_beats;
		bit                restore_len;

		// Directed table. Positions: block 1 ends at 5, the exact-fit
		// block at 11, the overrun block at 15, then 18 and 22.
		directed_rows = '{
			row_write(REG_FILE_LENGTH, FLEN_MAX),
			// first beat: signature only, byte taken as length low
			row_beat(8'h03, 1'b1, 4'd10, SIGNATURE),
			// reset pause of 1000 ms in the header
			row_beat(8'h00, 1'b1, 4'd5, 80'h00_03_03_E8_10),
			row_beat(8'h00), row_beat(8'hFF), row_beat(8'h5A),
			row_write(REG_PAUSE_MS, CFG_W'(PAUSE_MAX)),
			// block ends exactly at the file length: pause forced to 0
			row_write(REG_FILE_LENGTH, 24'd11),
			row_beat(8'h04, 1'b1, 4'd0, '0),
			row_beat(8'h00, 1'b1, 4'd5, 80'h00_04_00_00_10),
			row_beat(8'h80), row_beat(8'h7F), row_beat(8'h01), row_beat(8'hFE),
			// length high arrives past the end: still a full block
			row_write(REG_FILE_LENGTH, 24'd12),
			row_beat(8'h02),
			row_beat(8'h00, 1'b1, 4'd5, 80'h00_02_00_00_10),
			row_beat(8'hC3), row_beat(8'h3C),
			// spare indexes must leave both registers alone
			row_write(REG_SPARE_2, FLEN_MAX),
			row_write(REG_SPARE_3, 24'hAB_CDEF),
			row_write(REG_FILE_LENGTH, FLEN_MAX),
			row_beat(8'h01),
			row_beat(8'h00, 1'b1, 4'd5, 80'h00_01_FF_FF_10),
			row_beat(8'h55),
			row_write(REG_PAUSE_MS, '0),
			row_beat(8'h02),
			row_beat(8'h00, 1'b1, 4'd5, 80'h00_02_00_00_10),
			row_beat(8'hAA), row_beat(8'h11)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = ($urandom_range(0, 1) == 0);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				send_image_byte(directed_rows[i].value[BYTE_W-1:0], directed_rows[i].typed,
					directed_rows[i].n, directed_rows[i].bytes);
			end
		end

		// Random blocks. Every block is well formed; the file length is
		// pulled in now and then to hit the last-block and overrun cases,
		// and put back to the maximum so the conversion carries on.
		random_beats  = 0;
		while (random_beats < RANDOM_BEATS) begin
			calm        = ($urandom_range(0, 3) == 0);
			scenario    = $urandom_range(0, 9);
			restore_len = 1'b0;
			if ($urandom_range(0, 7) == 0) begin
				blen = LEN_W'($urandom_range(1, 200));
			end else begin
				blen = LEN_W'($urandom_range(1, 12));
			end

			case (scenario)
				0: write_reg(REG_PAUSE_MS, CFG_W'($urandom_range(0, 65535)));
				1: write_reg(REG_PAUSE_MS, '0);
				2: write_reg(REG_PAUSE_MS, CFG_W'(PAUSE_MAX));
				3: begin
					// block reaches the file length exactly
					write_reg(REG_FILE_LENGTH, CFG_W'(tr_pos + 2 + blen));
					restore_len = 1'b1;
				end
				4: begin
					// block runs past the file length
					write_reg(REG_FILE_LENGTH,
						CFG_W'(tr_pos + 2 + $urandom_range(0, blen - 1)));
					restore_len = 1'b1;
				end
				5: begin
					// length high byte already beyond the end
					write_reg(REG_FILE_LENGTH, CFG_W'(tr_pos + 1));
					restore_len = 1'b1;
				end
				6: begin
					// sender holds off until the output has drained
					in_valid <= 1'b0;
					wait_idle();
				end
				default: ;
			endcase

			send_image_byte(blen[7:0], 1'b0, '0, '0);
			send_image_byte(blen[15:8], 1'b0, '0, '0);
			for (int k = 0; k < blen; k++)
				send_image_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0, '0);

			if (restore_len)
				write_reg(REG_FILE_LENGTH, FLEN_MAX);
			random_beats += blen + 2;
		end

		// close the conversion one way or the other
		calm = 1'b0;
		if ($urandom_range(0, 1) == 0) begin
			end_reason = "zero length";
			send_image_byte(8'h00, 1'b0, '0, '0);
			send_image_byte(8'h00, 1'b0, '0, '0);
		end else begin
			end_reason = "file length reached";
			write_reg(REG_FILE_LENGTH, '0);
			send_image_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0, '0);
		end
		// after the end nothing more may come out
		repeat (12) send_image_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0, '0);
		in_valid <= 1'b0;

		while (container_q.size() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d image bytes in, %0d container bytes checked, %0d block headers",
			beats_sent, bytes_checked, headers_seen);
		$display("     %0d register writes, conversion closed by %s", writes_done, end_reason);
		if (fault_count == 0) begin
			$display("tape_block_reframer_core verification clean");
		end else begin
			$display("tape_block_reframer_core verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/tbr_pkg.sv
rtl/tbr_parser.sv
rtl/tbr_emitter.sv
rtl/tape_block_reframer_core.sv
test/tape_block_reframer_core_tb.sv
